// ===== rtl/core/cbp_pkg.sv =====
`default_nettype none

package cbp_pkg;

  // Number of de Casteljau interpolation levels in a cubic curve.
  localparam int BEZIER_LEVELS = 3;

  // Register stages in one interpolation level: the product, then the add.
  localparam int LERP_LATENCY = 2;

  // Cycles from an accepted input beat to its result, with no stall.
  localparam int PIPE_LATENCY = BEZIER_LEVELS * LERP_LATENCY;

  // Occupancy of the two register stages of one interpolation level.
  typedef struct packed {
    logic mul_busy;
    logic add_busy;
  } cbp_occ_t;

endpackage : cbp_pkg

`default_nettype wire

// ===== rtl/core/cbp_if.sv =====
`default_nettype none

// Input channel: four control values and the curve parameter in one beat.
interface cbp_in_if #(
  parameter int COORD_BITS  = 32,
  parameter int T_FRAC_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_BITS-1:0]  p0;
  logic signed [COORD_BITS-1:0]  p1;
  logic signed [COORD_BITS-1:0]  p2;
  logic signed [COORD_BITS-1:0]  p3;
  logic        [T_FRAC_BITS:0]   frac_t;

  modport source (output valid, output p0, output p1, output p2, output p3,
                  output frac_t, input ready);
  modport sink   (input valid, input p0, input p1, input p2, input p3,
                  input frac_t, output ready);
endinterface : cbp_in_if

// Result channel: one curve coordinate per beat.
interface cbp_out_if #(
  parameter int COORD_BITS = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_BITS-1:0]  point;

  modport source (output valid, output point, input ready);
  modport sink   (input valid, input point, output ready);
endinterface : cbp_out_if

`default_nettype wire

// ===== rtl/core/cbp_lerp_level.sv =====
`default_nettype none

// One de Casteljau level: LANES interpolations between neighboring points.
// Stage one forms (b - a) * t, stage two adds the floored product to a.
module cbp_lerp_level
  import cbp_pkg::*;
#(
  parameter int COORD_BITS  = 32,
  parameter int T_FRAC_BITS = 16,
  parameter int LANES       = 3
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         up_valid,
  output logic                         up_ready,
  input  logic signed [COORD_BITS-1:0] up_pts [LANES+1],
  input  logic        [T_FRAC_BITS:0]  up_t,
  output logic                         dn_valid,
  input  logic                         dn_ready,
  output logic signed [COORD_BITS-1:0] dn_pts [LANES],
  output logic        [T_FRAC_BITS:0]  dn_t,
  output cbp_occ_t                     occ
);

  localparam int PROD_BITS = COORD_BITS + T_FRAC_BITS + 2;
  localparam logic [T_FRAC_BITS:0] T_ONE = {1'b1, {T_FRAC_BITS{1'b0}}};

  logic                         mul_vld_r;
  logic                         mul_vld_nxt;
  logic                         mul_rdy;
  logic        [T_FRAC_BITS:0]  mul_t_r;
  logic signed [COORD_BITS-1:0] mul_base_r [LANES];
  logic signed [PROD_BITS-1:0]  mul_prod_r [LANES];

  logic                         add_vld_r;
  logic                         add_vld_nxt;
  logic                         add_rdy;
  logic        [T_FRAC_BITS:0]  add_t_r;
  logic signed [COORD_BITS-1:0] add_pts_r [LANES];

  logic signed [T_FRAC_BITS+1:0] t_s;
  logic signed [COORD_BITS:0]    diff [LANES];
  logic signed [PROD_BITS-1:0]   prod [LANES];
  logic signed [COORD_BITS-1:0]  sum  [LANES];

  // Each stage takes a beat when it is empty or its own beat moves on.
  assign add_rdy  = !add_vld_r || dn_ready;
  assign mul_rdy  = !mul_vld_r || add_rdy;
  assign up_ready = mul_rdy;

  assign mul_vld_nxt = mul_rdy ? up_valid : mul_vld_r;
  assign add_vld_nxt = add_rdy ? mul_vld_r : add_vld_r;

  // Difference of neighbors, one bit wider, times the parameter.
  always_comb begin
    t_s = {1'b0, up_t};
    for (int i = 0; i < LANES; i++) begin
      diff[i] = {up_pts[i+1][COORD_BITS-1], up_pts[i+1]}
              - {up_pts[i][COORD_BITS-1], up_pts[i]};
      prod[i] = PROD_BITS'(diff[i]) * PROD_BITS'(t_s);
    end
  end

  // Floor shift of the product is a plain bit select; the sum stays in the hull.
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      sum[i] = mul_base_r[i] + mul_prod_r[i][COORD_BITS+T_FRAC_BITS-1:T_FRAC_BITS];
    end
  end

  // Valid bits of both stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_vld_r <= 1'b0;
      add_vld_r <= 1'b0;
    end else begin
      mul_vld_r <= mul_vld_nxt;
      add_vld_r <= add_vld_nxt;
    end
  end

  // Product stage payload.
  always_ff @(posedge clk) begin
    if (mul_rdy && up_valid) begin
      mul_t_r <= up_t;
      for (int i = 0; i < LANES; i++) begin
        mul_base_r[i] <= up_pts[i];
        mul_prod_r[i] <= prod[i];
      end
    end
  end

  // Add stage payload.
  always_ff @(posedge clk) begin
    if (add_rdy && mul_vld_r) begin
      add_t_r <= mul_t_r;
      for (int i = 0; i < LANES; i++) begin
        add_pts_r[i] <= sum[i];
      end
    end
  end

  assign dn_valid = add_vld_r;
  assign dn_t     = add_t_r;
  assign dn_pts   = add_pts_r;

  assign occ.mul_busy = mul_vld_r;
  assign occ.add_busy = add_vld_r;

  // An accepted beat always lands in the product stage.
  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    up_valid && up_ready |=> mul_vld_r)
    else $error("accepted beat missing from product stage");

  // A product beat blocked by the add stage keeps its parameter.
  a_mul_holds: assert property (@(posedge clk) disable iff (!rst_n)
    mul_vld_r && !add_rdy |=> mul_vld_r && $stable(mul_t_r))
    else $error("stalled product stage changed");

  // A product beat that moves on shows up in the add stage.
  a_mul_moves: assert property (@(posedge clk) disable iff (!rst_n)
    mul_vld_r && add_rdy |=> add_vld_r)
    else $error("product beat lost on its way to the add stage");

  // The parameter is never above one inside the level.
  a_t_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    mul_vld_r |-> mul_t_r <= T_ONE)
    else $error("curve parameter above one inside a level");

endmodule : cbp_lerp_level

`default_nettype wire

// ===== rtl/core/cubic_bezier_point_top.sv =====
`default_nettype none

// Cubic Bezier point, one coordinate: each input beat carries four signed
// fixed-point control values and the curve parameter t (2^T_FRAC_BITS means
// 1.0, larger values are treated as 1.0), and yields one curve coordinate by
// de Casteljau's method. A full curve point takes one beat per axis. The three
// interpolation levels each hold a product stage and an add stage, and a new
// beat is taken every cycle when nothing stalls; the one multiplier per
// interpolation in each product stage sets the clock. Beats are independent
// and leave in the order taken.
module cubic_bezier_point_top
  import cbp_pkg::*;
#(
  parameter int COORD_BITS  = 32,
  parameter int T_FRAC_BITS = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  cbp_in_if.sink   in_ch,
  cbp_out_if.source out_ch
);

  localparam logic [T_FRAC_BITS:0] T_ONE = {1'b1, {T_FRAC_BITS{1'b0}}};

  logic signed [COORD_BITS-1:0] lvl0_pts [4];
  logic signed [COORD_BITS-1:0] lvl1_pts [3];
  logic signed [COORD_BITS-1:0] lvl2_pts [2];
  logic signed [COORD_BITS-1:0] lvl3_pts [1];
  logic        [T_FRAC_BITS:0]  t_clamp;
  logic        [T_FRAC_BITS:0]  lvl1_t;
  logic        [T_FRAC_BITS:0]  lvl2_t;
  logic        [T_FRAC_BITS:0]  lvl3_t;
  logic                         lvl1_valid;
  logic                         lvl1_ready;
  logic                         lvl2_valid;
  logic                         lvl2_ready;
  cbp_occ_t                     occ1;
  cbp_occ_t                     occ2;
  cbp_occ_t                     occ3;

  // Control values enter level one; t above one saturates to one.
  assign lvl0_pts[0] = in_ch.p0;
  assign lvl0_pts[1] = in_ch.p1;
  assign lvl0_pts[2] = in_ch.p2;
  assign lvl0_pts[3] = in_ch.p3;
  assign t_clamp     = (in_ch.frac_t > T_ONE) ? T_ONE : in_ch.frac_t;

  // First level: three interpolations.
  cbp_lerp_level #(
    .COORD_BITS (COORD_BITS),
    .T_FRAC_BITS(T_FRAC_BITS),
    .LANES      (3)
  ) u_level1 (
    .clk     (clk),
    .rst_n   (rst_n),
    .up_valid(in_ch.valid),
    .up_ready(in_ch.ready),
    .up_pts  (lvl0_pts),
    .up_t    (t_clamp),
    .dn_valid(lvl1_valid),
    .dn_ready(lvl1_ready),
    .dn_pts  (lvl1_pts),
    .dn_t    (lvl1_t),
    .occ     (occ1)
  );

  // Second level: two interpolations.
  cbp_lerp_level #(
    .COORD_BITS (COORD_BITS),
    .T_FRAC_BITS(T_FRAC_BITS),
    .LANES      (2)
  ) u_level2 (
    .clk     (clk),
    .rst_n   (rst_n),
    .up_valid(lvl1_valid),
    .up_ready(lvl1_ready),
    .up_pts  (lvl1_pts),
    .up_t    (lvl1_t),
    .dn_valid(lvl2_valid),
    .dn_ready(lvl2_ready),
    .dn_pts  (lvl2_pts),
    .dn_t    (lvl2_t),
    .occ     (occ2)
  );

  // Final level: its add stage is the output register.
  cbp_lerp_level #(
    .COORD_BITS (COORD_BITS),
    .T_FRAC_BITS(T_FRAC_BITS),
    .LANES      (1)
  ) u_level3 (
    .clk     (clk),
    .rst_n   (rst_n),
    .up_valid(lvl2_valid),
    .up_ready(lvl2_ready),
    .up_pts  (lvl2_pts),
    .up_t    (lvl2_t),
    .dn_valid(out_ch.valid),
    .dn_ready(out_ch.ready),
    .dn_pts  (lvl3_pts),
    .dn_t    (lvl3_t),
    .occ     (occ3)
  );

  assign out_ch.point = lvl3_pts[0];

  // An empty pipeline always takes a beat.
  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (occ1 == '0) && (occ2 == '0) && (occ3 == '0) |-> in_ch.ready)
    else $error("empty pipeline refused an input beat");

  // With the sink ready throughout, a beat reaches the output in fixed time.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $past(in_ch.valid && in_ch.ready, PIPE_LATENCY)
    && $past(out_ch.ready, 1) && $past(out_ch.ready, 2) && $past(out_ch.ready, 3)
    && $past(out_ch.ready, 4) && $past(out_ch.ready, 5)
    && $past(rst_n, 1) && $past(rst_n, 2) && $past(rst_n, 3)
    && $past(rst_n, 4) && $past(rst_n, 5)
    |-> out_ch.valid)
    else $error("result late with the sink ready");

  // The output holds a parameter that was clamped on entry.
  a_out_t: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> lvl3_t <= T_ONE)
    else $error("curve parameter above one at the output");

endmodule : cubic_bezier_point_top

`default_nettype wire
